/* sv/msz_pkg.sv */
// ----------------------------------------------------------------------------
// msz_pkg
// Types and constants shared by the sample-set parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package msz_pkg;

    // Parse phases
    typedef enum logic [4:0] {
        PH_MAGIC, PH_SIZE, PH_SKIPCHUNK, PH_NAME_MARK, PH_NAME_LEN, PH_NAME_CHARS,
        PH_TOP, PH_META_LEN, PH_META_CHARS, PH_UUID_LEN, PH_SKIP, PH_ZLEN, PH_ZHDR1,
        PH_ZHDR2, PH_ZMARK, PH_ZNAMELEN, PH_ZNAME, PH_SID, PH_SVAR, PH_KID, PH_KVAL,
        PH_DONE
    } t_phase;

    // Destination of a parameter value
    typedef enum logic [1:0] {
        TG_START, TG_LOOP, TG_END_OFS, TG_NONE
    } t_target;

    typedef enum logic [1:0] {
        TK_LOW, TK_HIGH, TK_ROOT, TK_NONE
    } t_keysel;

    // Result kinds
    localparam logic [1:0] KIND_SET_CHAR  = 2'd0;
    localparam logic [1:0] KIND_FILE_CHAR = 2'd1;
    localparam logic [1:0] KIND_ZONE      = 2'd2;
    localparam logic [1:0] KIND_END       = 2'd3;

    // End status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_TRUNCATED = 3'd2;
    localparam logic [2:0] ST_FORMAT    = 3'd3;
    localparam logic [2:0] ST_TOO_MANY  = 3'd4;
    localparam logic [2:0] ST_NO_ZONES  = 3'd5;

    // Tags and parameter ids
    localparam logic [7:0] TAG_META_A = 8'h12;
    localparam logic [7:0] TAG_META_B = 8'h1A;
    localparam logic [7:0] TAG_META_C = 8'h22;
    localparam logic [7:0] TAG_ZONE   = 8'h2A;
    localparam logic [7:0] TAG_UUID   = 8'h3A;
    localparam logic [7:0] MARKER     = 8'h0A;
    localparam logic [7:0] ID_10      = 8'h10;
    localparam logic [7:0] ID_18      = 8'h18;
    localparam logic [7:0] ID_20      = 8'h20;
    localparam logic [7:0] ID_28      = 8'h28;
    localparam logic [7:0] ID_35      = 8'h35;
    localparam logic [7:0] ID_3D      = 8'h3D;
    localparam logic [7:0] ID_45      = 8'h45;
    localparam logic [7:0] ID_48      = 8'h48;
    localparam logic [7:0] ID_50      = 8'h50;

    localparam logic [7:0] KEY_LOW_DEF  = 8'd0;
    localparam logic [7:0] KEY_TOP_DEF  = 8'd127;
    localparam logic [7:0] KEY_BASE_DEF = 8'd60;

    localparam logic [7:0] MAGIC0 = 8'h4B;
    localparam logic [7:0] MAGIC1 = 8'h6F;
    localparam logic [7:0] MAGIC2 = 8'h72;
    localparam logic [7:0] MAGIC3 = 8'h67;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        case (idx)
            2'd0:    magic_byte = MAGIC0;
            2'd1:    magic_byte = MAGIC1;
            2'd2:    magic_byte = MAGIC2;
            default: magic_byte = MAGIC3;
        endcase
    endfunction

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  zone_index;
        logic [4:0]  char_index;
        logic [7:0]  char_value;
        logic [31:0] sample_start;
        logic [31:0] sample_end;
        logic [7:0]  key_low;
        logic [7:0]  key_top;
        logic [7:0]  key_base;
        logic [4:0]  zones_found;
        logic [2:0]  status;
        logic        last_result;
    } t_result;

endpackage
`default_nettype wire

/* sv/msz_core.sv */
// ----------------------------------------------------------------------------
// msz_core
// Parse state; turns one accepted byte into up to three ordered result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module msz_core import msz_pkg::*; #(
    parameter int MAX_ZONES     = 16,
    parameter int FILE_NAME_LEN = 32,
    parameter int SET_NAME_LEN  = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_last_byte,
    output logic [1:0]         o_push_count,
    output t_result [2:0]      o_res
);
    localparam int ZW = $clog2(MAX_ZONES + 1);
    localparam logic [8:0] FN_LIM = 9'(FILE_NAME_LEN - 1);
    localparam logic [8:0] SN_LIM = 9'(SET_NAME_LEN - 1);

    t_phase              r_phase, n_phase, r_skip_next, n_skip_next;
    logic [1:0]          r_hdr, n_hdr, r_chunk_no, n_chunk_no;
    logic [31:0]         r_chunk_left, n_chunk_left, r_acc, n_acc, r_skip, n_skip;
    logic [2:0]          r_vcnt, n_vcnt, r_err, n_err;
    logic signed [33:0]  r_rest, n_rest;
    logic [7:0]          r_prev, n_prev, r_slen, n_slen, r_spos, n_spos;
    logic [31:0]         r_start, n_start, r_end, n_end;
    logic [7:0]          r_klo, n_klo, r_khi, n_khi, r_krt, n_krt;
    logic [ZW-1:0]       r_total, n_total, r_zone, n_zone;
    t_target             r_target, n_target;
    t_keysel             r_ksel, n_ksel;
    logic                r_early, n_early;

    logic                chr_v, rec_v, fl;
    logic [2:0]          fc;
    t_result             chr, rec, endr;
    logic [37:0]         vsh;
    logic [31:0]         tmp32;
    logic                hd;

    // Next-state for one byte
    always_comb begin
        n_phase = r_phase;  n_skip_next = r_skip_next; n_hdr = r_hdr;
        n_chunk_no = r_chunk_no; n_chunk_left = r_chunk_left; n_acc = r_acc;
        n_skip = r_skip; n_vcnt = r_vcnt; n_err = r_err; n_rest = r_rest;
        n_prev = r_prev; n_slen = r_slen; n_spos = r_spos; n_start = r_start;
        n_end = r_end; n_klo = r_klo; n_khi = r_khi; n_krt = r_krt;
        n_total = r_total; n_zone = r_zone; n_target = r_target;
        n_ksel = r_ksel; n_early = r_early;
        chr_v = 1'b0; rec_v = 1'b0; fl = 1'b0; fc = ST_OK;
        chr = '0; rec = '0; endr = '0; vsh = '0; tmp32 = '0; hd = 1'b0;

        case (r_phase)
            PH_MAGIC: begin
                if (i_data_byte != magic_byte(r_hdr)) begin
                    fl = 1'b1; fc = ST_BAD_MAGIC;
                end else if (r_hdr == 2'd3) begin
                    n_hdr = '0; n_chunk_left = '0; n_phase = PH_SIZE;
                end else begin
                    n_hdr = r_hdr + 2'd1;
                end
            end
            PH_SIZE: begin
                tmp32 = r_chunk_left | (32'(i_data_byte) << {r_hdr, 3'b000});
                n_chunk_left = tmp32;
                n_hdr = r_hdr + 2'd1;
                if (r_hdr == 2'd3) begin
                    if (r_chunk_no < 2'd2) begin
                        if (tmp32 == '0) n_chunk_no = r_chunk_no + 2'd1;
                        else n_phase = PH_SKIPCHUNK;
                    end else if (tmp32 == '0) begin
                        fl = 1'b1; fc = ST_FORMAT;
                    end else begin
                        n_phase = PH_NAME_MARK;
                    end
                end
            end
            PH_SKIPCHUNK: begin
                n_chunk_left = r_chunk_left - 32'd1;
                if (n_chunk_left == '0) begin
                    n_chunk_no = r_chunk_no + 2'd1; n_phase = PH_SIZE;
                end
            end
            PH_DONE: begin
            end
            default: begin
                n_chunk_left = r_chunk_left - 32'd1;
                case (r_phase)
                    PH_NAME_MARK: begin
                        if (i_data_byte != MARKER) begin
                            fl = 1'b1; fc = ST_FORMAT;
                        end else n_phase = PH_NAME_LEN;
                    end
                    PH_NAME_LEN, PH_META_LEN: begin
                        n_slen = i_data_byte; n_spos = '0;
                        if (i_data_byte == '0) n_phase = PH_TOP;
                        else if (r_phase == PH_NAME_LEN) n_phase = PH_NAME_CHARS;
                        else n_phase = PH_META_CHARS;
                    end
                    PH_NAME_CHARS, PH_META_CHARS: begin
                        if (r_phase == PH_NAME_CHARS && {1'b0, r_spos} < SN_LIM) begin
                            chr_v = 1'b1;
                            chr.result_kind = KIND_SET_CHAR;
                            chr.char_index = r_spos[4:0];
                            chr.char_value = i_data_byte;
                        end
                        n_spos = r_spos + 8'd1;
                        if (n_spos >= r_slen) n_phase = PH_TOP;
                    end
                    PH_UUID_LEN: begin
                        if (i_data_byte == '0) n_phase = PH_TOP;
                        else begin
                            n_skip = 32'(i_data_byte); n_skip_next = PH_TOP;
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        n_skip = r_skip - 32'd1;
                        if (n_skip == '0) n_phase = r_skip_next;
                    end
                    PH_ZLEN, PH_SVAR: begin
                        vsh = 38'(i_data_byte[6:0]) << (6'(r_vcnt) * 6'd7);
                        n_acc = r_acc | vsh[31:0];
                        n_vcnt = r_vcnt + 3'd1;
                        if (!(i_data_byte[7] && n_vcnt < 3'd5)) begin
                            if (r_phase == PH_ZLEN) begin
                                n_rest = {2'b00, n_acc}; n_phase = PH_ZHDR1;
                            end else begin
                                n_rest = r_rest - 34'(n_vcnt);
                                if (r_target == TG_START) n_start = n_acc;
                                else if (r_target == TG_END_OFS) n_end = n_acc;
                                if (n_rest <= 0) begin
                                    rec_v = 1'b1; n_phase = PH_TOP;
                                end else n_phase = PH_SID;
                            end
                        end
                    end
                    PH_ZHDR1: n_phase = PH_ZHDR2;
                    PH_ZHDR2: n_phase = PH_ZMARK;
                    PH_ZMARK: begin
                        if (i_data_byte != MARKER) begin
                            fl = 1'b1; fc = ST_FORMAT;
                        end else n_phase = PH_ZNAMELEN;
                    end
                    PH_ZNAMELEN: begin
                        n_slen = i_data_byte; n_spos = '0;
                        n_rest = r_rest - 34'sd4 - 34'(i_data_byte);
                        n_prev = '0;
                        if (n_rest <= 0 && n_chunk_left >= 32'(i_data_byte)) begin
                            rec_v = 1'b1; n_early = 1'b1;
                            n_phase = (i_data_byte == '0) ? PH_TOP : PH_ZNAME;
                        end else if (i_data_byte == '0) begin
                            if (n_rest <= 0) begin
                                rec_v = 1'b1; n_phase = PH_TOP;
                            end else n_phase = PH_SID;
                        end else n_phase = PH_ZNAME;
                    end
                    PH_ZNAME: begin
                        if ({1'b0, r_spos} < FN_LIM) begin
                            chr_v = 1'b1;
                            chr.result_kind = KIND_FILE_CHAR;
                            chr.zone_index = 4'(r_zone);
                            chr.char_index = r_spos[4:0];
                            chr.char_value = i_data_byte;
                        end
                        n_spos = r_spos + 8'd1;
                        if (n_spos >= r_slen) begin
                            if (r_early) n_phase = PH_TOP;
                            else if (r_rest <= 0) begin
                                rec_v = 1'b1; n_phase = PH_TOP;
                            end else n_phase = PH_SID;
                        end
                    end
                    PH_KVAL: begin
                        if (r_ksel == TK_LOW) n_klo = i_data_byte;
                        else if (r_ksel == TK_HIGH) n_khi = i_data_byte;
                        else n_krt = i_data_byte;
                        n_rest = r_rest - 34'sd1;
                        if (n_rest <= 0) begin
                            rec_v = 1'b1; n_phase = PH_TOP;
                        end else n_phase = PH_KID;
                    end
                    default: begin
                    end
                endcase

                // Sample id; a descending id is re-read as a key id
                if (r_phase == PH_SID) begin
                    if (i_data_byte < r_prev) begin
                        n_prev = '0; n_phase = PH_KID;
                    end else begin
                        hd = 1'b1;
                        n_prev = i_data_byte;
                        n_rest = r_rest - 34'sd1;
                        if (i_data_byte == ID_10 || i_data_byte == ID_18 ||
                            i_data_byte == ID_20) begin
                            n_acc = '0; n_vcnt = '0;
                            n_target = (i_data_byte == ID_10) ? TG_START :
                                       (i_data_byte == ID_18) ? TG_LOOP : TG_END_OFS;
                            n_phase = PH_SVAR;
                        end else if (i_data_byte == ID_45 || i_data_byte == ID_48 ||
                                     i_data_byte == ID_50) begin
                            n_rest = (i_data_byte == ID_45) ? r_rest - 34'sd5
                                                            : r_rest - 34'sd2;
                            n_skip = (i_data_byte == ID_45) ? 32'd4 : 32'd1;
                            n_phase = PH_SKIP;
                            if (n_rest <= 0) begin
                                rec_v = 1'b1; n_skip_next = PH_TOP;
                            end else n_skip_next = PH_SID;
                        end else begin
                            fl = 1'b1; fc = ST_FORMAT;
                        end
                    end
                end

                // Key id; a descending id closes the zone and is re-read as a tag
                if ((r_phase == PH_SID || r_phase == PH_KID) && !hd) begin
                    if (i_data_byte < n_prev) begin
                        rec_v = 1'b1; n_phase = PH_TOP;
                    end else begin
                        hd = 1'b1;
                        n_prev = i_data_byte;
                        n_rest = r_rest - 34'sd1;
                        if (i_data_byte == ID_10 || i_data_byte == ID_18 ||
                            i_data_byte == ID_20) begin
                            n_ksel = (i_data_byte == ID_10) ? TK_LOW :
                                     (i_data_byte == ID_18) ? TK_HIGH : TK_ROOT;
                            n_phase = PH_KVAL;
                        end else if (i_data_byte == ID_28 || i_data_byte == ID_35 ||
                                     i_data_byte == ID_3D || i_data_byte == ID_45 ||
                                     i_data_byte == ID_50) begin
                            // colour id skips five bytes yet counts four
                            n_rest = (i_data_byte == ID_28) ? r_rest - 34'sd2
                                                            : r_rest - 34'sd5;
                            n_skip = (i_data_byte == ID_28) ? 32'd1 :
                                     (i_data_byte == ID_50) ? 32'd5 : 32'd4;
                            n_phase = PH_SKIP;
                            if (n_rest <= 0) begin
                                rec_v = 1'b1; n_skip_next = PH_TOP;
                            end else n_skip_next = PH_KID;
                        end else begin
                            fl = 1'b1; fc = ST_FORMAT;
                        end
                    end
                end

                // Capture the record before a zone tag reloads the defaults
                rec.result_kind  = KIND_ZONE;
                rec.zone_index   = 4'(r_zone);
                rec.sample_start = n_start;
                rec.sample_end   = n_end;
                rec.key_low      = n_klo;
                rec.key_top      = n_khi;
                rec.key_base     = n_krt;
                if (rec_v) n_total = r_total + ZW'(1);

                // Top-level tag, directly or re-read
                if ((r_phase == PH_TOP || ((r_phase == PH_SID || r_phase == PH_KID)
                                           && !hd)) && !fl) begin
                    if (i_data_byte == TAG_META_A || i_data_byte == TAG_META_B ||
                        i_data_byte == TAG_META_C) begin
                        n_phase = PH_META_LEN;
                    end else if (i_data_byte == TAG_UUID) begin
                        n_phase = PH_UUID_LEN;
                    end else if (i_data_byte == TAG_ZONE) begin
                        if (n_total >= ZW'(MAX_ZONES)) begin
                            fl = 1'b1; fc = ST_TOO_MANY;
                        end else begin
                            n_zone = n_total;
                            n_start = '0; n_end = '0;
                            n_klo = KEY_LOW_DEF; n_khi = KEY_TOP_DEF;
                            n_krt = KEY_BASE_DEF;
                            n_early = 1'b0; n_acc = '0; n_vcnt = '0;
                            n_phase = PH_ZLEN;
                        end
                    end else begin
                        fl = 1'b1; fc = ST_FORMAT;
                    end
                end
            end
        endcase

        // Keep the first error and stop parsing
        if (fl) begin
            if (r_err == ST_OK) n_err = fc;
            n_phase = PH_DONE;
        end

        // End of chunk three
        if (r_phase != PH_MAGIC && r_phase != PH_SIZE && r_phase != PH_SKIPCHUNK &&
            r_phase != PH_DONE && n_chunk_left == '0 && n_phase != PH_DONE) begin
            if (!(n_phase == PH_TOP || (n_phase == PH_SKIP && n_skip_next == PH_TOP))) begin
                if (n_err == ST_OK) n_err = ST_FORMAT;
            end
            n_phase = PH_DONE;
        end

        // End status word
        endr.result_kind = KIND_END;
        endr.zones_found = 5'(n_total);
        if (n_err != ST_OK) endr.status = n_err;
        else if (n_phase == PH_MAGIC) endr.status = ST_BAD_MAGIC;
        else if (n_phase != PH_DONE) endr.status = ST_TRUNCATED;
        else if (n_total == '0) endr.status = ST_NO_ZONES;
        else endr.status = ST_OK;
    end

    // Pack the words in order: character, record, end status
    always_comb begin
        o_res = '0;
        o_push_count = '0;
        if (chr_v) begin
            o_res[o_push_count] = chr; o_push_count = o_push_count + 2'd1;
        end
        if (rec_v) begin
            o_res[o_push_count] = rec; o_push_count = o_push_count + 2'd1;
        end
        if (i_last_byte) begin
            o_res[o_push_count] = endr; o_push_count = o_push_count + 2'd1;
        end
        if (o_push_count != '0) o_res[o_push_count - 2'd1].last_result = 1'b1;
    end

    // Advance state on each accepted byte; the last byte restarts the parser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_phase <= PH_MAGIC;  r_skip_next <= PH_TOP; r_hdr <= '0;
            r_chunk_no <= '0; r_chunk_left <= '0; r_acc <= '0; r_skip <= '0;
            r_vcnt <= '0; r_err <= ST_OK; r_rest <= '0; r_prev <= '0;
            r_slen <= '0; r_spos <= '0; r_start <= '0; r_end <= '0;
            r_klo <= KEY_LOW_DEF; r_khi <= KEY_TOP_DEF; r_krt <= KEY_BASE_DEF;
            r_total <= '0; r_zone <= '0; r_target <= TG_NONE; r_ksel <= TK_NONE;
            r_early <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;  r_skip_next <= n_skip_next; r_hdr <= n_hdr;
            r_chunk_no <= n_chunk_no; r_chunk_left <= n_chunk_left; r_acc <= n_acc;
            r_skip <= n_skip; r_vcnt <= n_vcnt; r_err <= n_err; r_rest <= n_rest;
            r_prev <= n_prev; r_slen <= n_slen; r_spos <= n_spos;
            r_start <= n_start; r_end <= n_end;
            r_klo <= n_klo; r_khi <= n_khi; r_krt <= n_krt;
            r_total <= n_total; r_zone <= n_zone; r_target <= n_target;
            r_ksel <= n_ksel; r_early <= n_early;
        end
    end

endmodule
`default_nettype wire

/* sv/multisample_zone_parser.sv */
// ----------------------------------------------------------------------------
// multisample_zone_parser
// Sample-set file parser: one byte in, characters, zone records and status out.
// ----------------------------------------------------------------------------
// A byte's result words are registered in the output buffer when it is accepted.
// Throughput: one byte per cycle; a byte gives at most three words, queued in a
// four-word output buffer, and input is taken while the buffer holds one or less.
// Reset: synchronous active-low reset empties the buffer and restores the
// parser to the magic check; the final byte of a file does the same for the parser.
`timescale 1ns / 1ps
`default_nettype none
module multisample_zone_parser import msz_pkg::*; #(
    parameter int MAX_ZONES     = 16,
    parameter int FILE_NAME_LEN = 32,
    parameter int SET_NAME_LEN  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_result_kind,
    output logic [3:0]       o_zone_index,
    output logic [4:0]       o_char_index,
    output logic [7:0]       o_char_value,
    output logic [31:0]      o_sample_start,
    output logic [31:0]      o_sample_end,
    output logic [7:0]       o_key_low,
    output logic [7:0]       o_key_top,
    output logic [7:0]       o_key_base,
    output logic [4:0]       o_zones_found,
    output logic [2:0]       o_status,
    output logic             o_last_result
);
    logic           accept, pop;
    logic [1:0]     push_count;
    t_result [2:0]  res;
    t_result        r_buf [4];
    logic [1:0]     r_head, r_tail;
    logic [2:0]     r_count;
    t_result        head;

    assign o_ready = (r_count <= 3'd1);
    assign accept  = i_valid && o_ready;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;

    msz_core #(
        .MAX_ZONES     (MAX_ZONES),
        .FILE_NAME_LEN (FILE_NAME_LEN),
        .SET_NAME_LEN  (SET_NAME_LEN)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_push_count (push_count),
        .o_res        (res)
    );

    // Write the new words at the tail
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (push_count > 2'd0) r_buf[r_tail]        <= res[0];
            if (push_count > 2'd1) r_buf[r_tail + 2'd1] <= res[1];
            if (push_count > 2'd2) r_buf[r_tail + 2'd2] <= res[2];
        end
    end

    // Track head, tail and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0; r_tail <= '0; r_count <= '0;
        end else begin
            if (accept) r_tail <= r_tail + push_count;
            if (pop) r_head <= r_head + 2'd1;
            r_count <= r_count + (accept ? 3'(push_count) : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    assign head = r_buf[r_head];
    assign o_result_kind  = head.result_kind;
    assign o_zone_index   = head.zone_index;
    assign o_char_index   = head.char_index;
    assign o_char_value   = head.char_value;
    assign o_sample_start = head.sample_start;
    assign o_sample_end   = head.sample_end;
    assign o_key_low      = head.key_low;
    assign o_key_top      = head.key_top;
    assign o_key_base     = head.key_base;
    assign o_zones_found  = head.zones_found;
    assign o_status       = head.status;
    assign o_last_result  = head.last_result;

endmodule
`default_nettype wire

/* sv/msz_checker.sv */
// ----------------------------------------------------------------------------
// msz_checker
// Port-level checks on the parser's result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module msz_checker import msz_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [1:0]  o_result_kind,
    input wire logic [31:0] o_sample_start,
    input wire logic [4:0]  o_zones_found,
    input wire logic [2:0]  o_status,
    input wire logic        o_last_result
);
    // Hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result word dropped");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_sample_start) && $stable(o_result_kind))
        else $error("stalled result changed");

    // End status always closes its byte's words and carries a legal code
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_END |-> o_last_result && o_status <= ST_NO_ZONES)
        else $error("bad end status word");

    // Only the end status carries count and status
    a_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != KIND_END |-> o_status == ST_OK && o_zones_found == '0)
        else $error("status on a data word");

endmodule

bind multisample_zone_parser msz_checker u_msz_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_result_kind  (o_result_kind),
    .o_sample_start (o_sample_start),
    .o_zones_found  (o_zones_found),
    .o_status       (o_status),
    .o_last_result  (o_last_result)
);
`default_nettype wire
